FILE: rtl/mrw_pkg.sv
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared types and constants of the Miller-Rabin witness test block.
// ----------------------------------------------------------------------------
package mrw_pkg;

   localparam int FIELD_WIDTH     = 63;
   localparam int REQ_TDATA_WIDTH = 128;
   localparam int RSP_TDATA_WIDTH = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SPLIT,
      ST_POW,
      ST_MUL,
      ST_TEST,
      ST_DONE
   } mrw_state_type;

   typedef enum logic [1:0] {
      MK_POW_MUL,
      MK_POW_SQR,
      MK_TEST_SQR
   } mrw_mul_kind_type;

   typedef struct packed {
      logic invalid_input;
      logic probable_prime;
   } mrw_result_type;

endpackage

FILE: rtl/mrw_modadd.sv
// ----------------------------------------------------------------------------
// mrw_modadd
// Shared modular adder: (x + y + cin) mod n for x, y < n, sum kept one bit wider than the operands.
// ----------------------------------------------------------------------------
module mrw_modadd #(
   parameter int W = 63
) (
   input  logic [W-1:0] x,
   input  logic [W-1:0] y,
   input  logic         cin,
   input  logic [W-1:0] n,
   output logic [W-1:0] r
);

   logic [W:0] sum;
   logic [W:0] diff;

   assign sum  = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, cin};
   assign diff = sum - {1'b0, n};
   assign r    = (sum >= {1'b0, n}) ? diff[W-1:0] : sum[W-1:0];

endmodule

FILE: rtl/mrw_core.sv
// ----------------------------------------------------------------------------
// mrw_core
// Sequencer and datapath: base reduction, n-1 split, modular power and the
// squaring test, all through one shared modular adder.
// ----------------------------------------------------------------------------
module mrw_core #(
   parameter int W = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start_valid,
   output logic                    start_ready,
   input  logic [W-1:0]            base,
   input  logic [W-1:0]            modulus,
   output logic                    done_valid,
   input  logic                    done_ready,
   output mrw_pkg::mrw_result_type done_result
);

   localparam int TW = $clog2(W);
   localparam logic [W-1:0] ONE = W'(1);

   mrw_pkg::mrw_state_type    state_ff, state_in;
   mrw_pkg::mrw_mul_kind_type kind_ff, kind_in;
   mrw_pkg::mrw_result_type   result_ff, result_in;

   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  e_ff, e_in;
   logic [W-1:0]  mx_ff, mx_in;
   logic [W-1:0]  my_ff, my_in;
   logic [W-1:0]  macc_ff, macc_in;
   logic [TW-1:0] t_ff, t_in;
   logic [TW-1:0] idx_ff, idx_in;

   logic [W-1:0] ad_x, ad_y, ad_r, nm1;
   logic         ad_cin;

   mrw_modadd #(.W(W)) u_modadd (
      .x   (ad_x),
      .y   (ad_y),
      .cin (ad_cin),
      .n   (n_ff),
      .r   (ad_r)
   );

   assign nm1         = n_ff - ONE;
   assign start_ready = (state_ff == mrw_pkg::ST_IDLE);
   assign done_valid  = (state_ff == mrw_pkg::ST_DONE);
   assign done_result = result_ff;

   always_comb begin
      ad_x   = mx_ff;
      ad_y   = mx_ff;
      ad_cin = 1'b0;
      case (state_ff)
         mrw_pkg::ST_REDUCE: begin
            ad_x   = macc_ff;
            ad_y   = macc_ff;
            ad_cin = my_ff[W-1];
         end
         mrw_pkg::ST_MUL: begin
            if (my_ff[0]) begin
               ad_x = macc_ff;
            end
         end
         default: begin
            ad_x = mx_ff;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      result_in = result_ff;
      n_in      = n_ff;
      x_in      = x_ff;
      acc_in    = acc_ff;
      e_in      = e_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      macc_in   = macc_ff;
      t_in      = t_ff;
      idx_in    = idx_ff;
      case (state_ff)
         mrw_pkg::ST_IDLE: begin
            if (start_valid) begin
               if (!modulus[0] || modulus == ONE) begin
                  result_in = '{invalid_input: 1'b1, probable_prime: 1'b0};
                  state_in  = mrw_pkg::ST_DONE;
               end else begin
                  n_in     = modulus;
                  my_in    = base;
                  macc_in  = '0;
                  idx_in   = TW'(W - 1);
                  e_in     = {1'b0, modulus[W-1:1]};
                  t_in     = TW'(1);
                  state_in = mrw_pkg::ST_REDUCE;
               end
            end
         end
         mrw_pkg::ST_REDUCE: begin
            macc_in = ad_r;
            my_in   = {my_ff[W-2:0], 1'b0};
            if (idx_ff == '0) begin
               x_in     = ad_r;
               state_in = mrw_pkg::ST_SPLIT;
            end else begin
               idx_in = idx_ff - TW'(1);
            end
         end
         mrw_pkg::ST_SPLIT: begin
            if (e_ff[0]) begin
               acc_in   = ONE;
               state_in = mrw_pkg::ST_POW;
            end else begin
               e_in = {1'b0, e_ff[W-1:1]};
               t_in = t_ff + TW'(1);
            end
         end
         mrw_pkg::ST_POW: begin
            macc_in = '0;
            mx_in   = x_ff;
            if (e_ff == '0) begin
               state_in = mrw_pkg::ST_TEST;
            end else if (e_ff[0]) begin
               my_in    = acc_ff;
               kind_in  = mrw_pkg::MK_POW_MUL;
               state_in = mrw_pkg::ST_MUL;
            end else begin
               my_in    = x_ff;
               kind_in  = mrw_pkg::MK_POW_SQR;
               state_in = mrw_pkg::ST_MUL;
            end
         end
         mrw_pkg::ST_TEST: begin
            macc_in  = '0;
            mx_in    = acc_ff;
            my_in    = acc_ff;
            kind_in  = mrw_pkg::MK_TEST_SQR;
            state_in = mrw_pkg::ST_MUL;
         end
         mrw_pkg::ST_MUL: begin
            if (my_ff == '0) begin
               case (kind_ff)
                  mrw_pkg::MK_POW_MUL: begin
                     acc_in   = macc_ff;
                     e_in     = {e_ff[W-1:1], 1'b0};
                     state_in = mrw_pkg::ST_POW;
                  end
                  mrw_pkg::MK_POW_SQR: begin
                     x_in     = macc_ff;
                     e_in     = {1'b0, e_ff[W-1:1]};
                     state_in = mrw_pkg::ST_POW;
                  end
                  default: begin
                     t_in   = t_ff - TW'(1);
                     acc_in = macc_ff;
                     if (macc_ff == ONE && acc_ff != ONE && acc_ff != nm1) begin
                        result_in = '{invalid_input: 1'b0, probable_prime: 1'b0};
                        state_in  = mrw_pkg::ST_DONE;
                     end else if (t_ff == TW'(1)) begin
                        result_in = '{invalid_input: 1'b0,
                                      probable_prime: (macc_ff == ONE)};
                        state_in  = mrw_pkg::ST_DONE;
                     end else begin
                        state_in = mrw_pkg::ST_TEST;
                     end
                  end
               endcase
            end else if (my_ff[0]) begin
               macc_in = ad_r;
               my_in   = {my_ff[W-1:1], 1'b0};
            end else begin
               mx_in = ad_r;
               my_in = {1'b0, my_ff[W-1:1]};
            end
         end
         mrw_pkg::ST_DONE: begin
            if (done_ready) begin
               state_in = mrw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      result_ff <= result_in;
      n_ff      <= n_in;
      x_ff      <= x_in;
      acc_ff    <= acc_in;
      e_ff      <= e_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      macc_ff   <= macc_in;
      t_ff      <= t_in;
      idx_ff    <= idx_in;
   end

endmodule

FILE: rtl/miller_rabin_witness_test_top.sv
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_top
// Strong probable-prime test of one modulus against one witness base.
// ----------------------------------------------------------------------------
// An invalid modulus goes straight to the done state; otherwise the core reduces
// the base, strips the factors of two from n-1, and forms each modular product
// by shift-and-add over the multiplier bits, for the power and the squaring test.
// Throughput: one transaction at a time; the shared modular adder sets the pace.
// Reset clears the sequencer and the response valid.
module miller_rabin_witness_test_top #(
   parameter int MODULUS_WIDTH = 63
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [62:0] witness_base, [125:63] modulus, [127:126] zero
   input  logic [mrw_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] probable_prime, [1] invalid_input, [7:2] zero
   output logic [mrw_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata
);

   localparam int W  = MODULUS_WIDTH;
   localparam int FW = mrw_pkg::FIELD_WIDTH;

   logic [63:0]             base_ext, mod_ext;
   logic                    done_valid, done_ready, done_fire;
   mrw_pkg::mrw_result_type done_result;
   mrw_pkg::mrw_result_type rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   assign base_ext = {1'b0, req_tdata[FW-1:0]};
   assign mod_ext  = {1'b0, req_tdata[2*FW-1:FW]};

   mrw_core #(.W(W)) u_core (
      .clock       (clock),
      .reset       (reset),
      .start_valid (req_tvalid),
      .start_ready (req_tready),
      .base        (base_ext[W-1:0]),
      .modulus     (mod_ext[W-1:0]),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_result (done_result)
   );

   assign done_ready = !rsp_valid_ff || rsp_tready;
   assign done_fire  = done_valid && done_ready;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_data_in  = done_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mrw_pkg::RSP_TDATA_WIDTH - 2){1'b0}}, rsp_data_ff};

   a_invalid_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("invalid_input and probable_prime both set");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("core still ready after accepting a transaction");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      done_fire |=> (rsp_tvalid && rsp_data_ff == $past(done_result)))
      else $error("finished result not loaded into the response register");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the Miller-Rabin witness test block against an in-bench model of the
// strong probable-prime test. Directed cases cover invalid moduli, base
// reduction, bases that are multiples of the modulus, strong pseudoprimes,
// nontrivial square roots of one and the widest moduli. A random phase mixes
// primes, odd composites and malformed moduli. Both stream sides idle at
// random, and a long response hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 8_000_000;

   typedef struct {
      mrw_pkg::mrw_result_type   verdict;
      logic [62:0]               base;
      logic [62:0]               modulus;
   } witness_case_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [mrw_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [mrw_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata;

   witness_case_type    pending_verdicts[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  rsp_hold = 0;
   bit                  calm = 1'b0;

   logic [62:0] notable_moduli[10] = '{
      63'd3, 63'd65537, 63'd998244353, 63'd1000000007, 63'd4294967291,
      63'd2305843009213693951, 63'd9223372036854775783, 63'd2047,
      63'd3215031751, 63'd561
   };

   miller_rabin_witness_test_top #(
      .MODULUS_WIDTH (mrw_pkg::FIELD_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] n);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      p = p % {64'd0, n};
      return p[63:0];
   endfunction

   function automatic logic [63:0] mod_power(logic [63:0] x, logic [63:0] e,
                                             logic [63:0] n);
      logic [63:0] acc;
      acc = 64'd1;
      while (e != 0) begin
         if (e[0])
            acc = mod_product(acc, x, n);
         x = mod_product(x, x, n);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic mrw_pkg::mrw_result_type witness_verdict(logic [62:0] base,
                                                               logic [62:0] modulus);
      mrw_pkg::mrw_result_type   r;
      logic [63:0]               n;
      logic [63:0]               odd_part;
      logic [63:0]               x;
      logic [63:0]               sq;
      int                        twos;
      bit                        passed;
      n = {1'b0, modulus};
      r.invalid_input = 1'b0;
      r.probable_prime = 1'b0;
      if (n < 3 || !n[0]) begin
         r.invalid_input = 1'b1;
         return r;
      end
      odd_part = n - 1;
      twos = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      x = mod_power({1'b0, base} % n, odd_part, n);
      sq = 0;
      passed = 1'b1;
      while (twos > 0) begin
         twos--;
         sq = mod_product(x, x, n);
         // nontrivial square root of one
         if (sq == 1 && x != 1 && x != n - 1) begin
            passed = 1'b0;
            break;
         end
         x = sq;
      end
      r.probable_prime = passed && sq == 1;
      return r;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 24);
      return $urandom_range(100, 600);
   endfunction

   function automatic logic [62:0] random_bits();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[62:0];
   endfunction

   function automatic logic [62:0] small_prime();
      logic [62:0]   c;
      bit            found;
      int            d;
      do begin
         c = 63'($urandom_range(1, 524287)) * 2 + 1;
         found = 1'b1;
         for (d = 3; 63'(d) * 63'(d) <= c; d += 2) begin
            if (c % 63'(d) == 0) begin
               found = 1'b0;
               break;
            end
         end
      end while (!found);
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic send_witness(input logic [62:0] base, input logic [62:0] modulus);
      witness_case_type   item;
      int                 gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, modulus, base};
      do @(posedge clock); while (!req_tready);
      item.verdict = witness_verdict(base, modulus);
      item.base = base;
      item.modulus = modulus;
      pending_verdicts.push_back(item);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   // ---------------------------------------------------------------- response side

   initial begin : response_sink
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall = pick_gap();
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_responses
      witness_case_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("response with none outstanding, tdata %0h",
                                      rsp_tdata));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[0] !== want.verdict.probable_prime)
               report_mismatch($sformatf("probable_prime %b exp %b (a=%0d n=%0d)",
                  rsp_tdata[0], want.verdict.probable_prime, want.base, want.modulus));
            if (rsp_tdata[1] !== want.verdict.invalid_input)
               report_mismatch($sformatf("invalid_input %b exp %b (a=%0d n=%0d)",
                  rsp_tdata[1], want.verdict.invalid_input, want.base, want.modulus));
            if (rsp_tdata[7:2] !== 6'd0)
               report_mismatch($sformatf("padding %b not zero (a=%0d n=%0d)",
                  rsp_tdata[7:2], want.base, want.modulus));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_invalid_moduli();
      send_witness(63'd1, 63'd0);
      send_witness(63'd1, 63'd1);
      send_witness(63'h7fff_ffff_ffff_ffff, 63'd2);
      send_witness(63'd5, 63'd4);
      send_witness(63'h7fff_ffff_ffff_ffff, 63'h7fff_ffff_ffff_fffe);
   endtask

   task automatic test_special_witnesses();
      send_witness(63'd1, 63'd3);
      send_witness(63'd2, 63'd3);
      send_witness(63'd3, 63'd3);       // base equal to modulus
      send_witness(63'd0, 63'd7);       // zero base
      send_witness(63'd14, 63'd7);      // larger multiple of modulus
      send_witness(63'd2, 63'd341);     // nontrivial root of one
      send_witness(63'd2, 63'd2047);    // strong pseudoprime to base 2
      send_witness(63'd2, 63'd561);
      send_witness(63'd3, 63'd998244353);
   endtask

   task automatic test_wide_moduli();
      send_witness(63'h7fff_ffff_ffff_ffff, 63'd9223372036854775783);
      send_witness(63'd9223372036854775782, 63'd9223372036854775783);
      send_witness(63'h7fff_ffff_ffff_ffff, 63'h7fff_ffff_ffff_ffff);
      send_witness(63'd2, 63'd2305843009213693951);
      send_witness(63'd5, 63'd4294967291);
      send_witness(63'd7, 63'd3215031751);
   endtask

   task automatic test_output_backpressure();
      calm = 1'b1;
      rsp_hold = 40000;
      repeat (4) send_witness(random_bits(), notable_moduli[$urandom_range(0, 9)]);
      calm = 1'b0;
      wait_for_drain();
   endtask

   task automatic test_random_witnesses();
      logic [62:0]   n;
      logic [62:0]   a;
      int            width;
      int            pick;
      for (int i = 0; i < 76; i++) begin
         calm = (i >= 40 && i < 60);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            n = ($urandom_range(0, 1) == 0) ? 63'($urandom_range(0, 2))
                                            : random_bits() & ~63'd1;
         end else if (pick < 30) begin
            n = notable_moduli[$urandom_range(0, 9)];
         end else if (pick < 45) begin
            n = small_prime();
         end else begin
            width = $urandom_range(2, 63);
            n = random_bits() >> (63 - width);
            n[width-1] = 1'b1;
            n[0] = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (n < 3)
            a = random_bits();
         else if (pick < 85)
            a = 63'({1'b0, random_bits()} % {1'b0, n - 63'd1}) + 63'd1;
         else if (pick < 95)
            a = random_bits();
         else if (pick < 98)
            a = n - 63'd1;
         else
            a = n * 63'($urandom_range(0, 2));
         send_witness(a, n);
         if (i == 70)
            wait_for_drain();
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_invalid_moduli();
      wait_for_drain();
      test_special_witnesses();
      wait_for_drain();
      test_wide_moduli();
      wait_for_drain();
      test_output_backpressure();
      test_random_witnesses();
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: miller_rabin_witness_test_top.f
rtl/mrw_pkg.sv
rtl/mrw_modadd.sv
rtl/mrw_core.sv
rtl/miller_rabin_witness_test_top.sv
sim/tb_top.sv
